FILE: rtl/mme_pkg.sv
package mme_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;

  localparam int unsigned IDX_W      = 3;
  localparam int unsigned DIM_W      = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned ACC_W      = 35;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_OF_A  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_OF_B  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic rd_vld;
    logic clr;
  } mac_ctl_t;

endpackage

FILE: rtl/matrix_multiply_engine.sv
// Dense matrix product C = A x B on signed Q8.8 elements.
// Slave stream: tuser carries the command (write A, write B, compute);
// tdata carries row, col and value. A write item lands in the on-chip
// store; the next item may follow at once.
// A compute item walks the stores and emits rows_of_a x cols_of_b
// results on the master stream in column-major order, tlast on the last.
// Each result takes one dual read of the A and B stores per inner step;
// then the read, multiply and accumulate stages drain before the result
// is registered. No input is taken while a product is being worked out.
// The master side has one output register; while it holds a result the
// receiver has not taken, the engine stalls before loading the next one,
// but a new item is still accepted once the product is complete.
// Configuration is a plain write port: index 0 rows_of_a, 1 inner_size,
// 2 cols_of_b; values above MAX_DIM act as MAX_DIM.
// Reset sets all three dimensions to 8 and empties the output register;
// the stores keep no reset and must be written before they are used.
module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row[2:0], col[5:3], value[21:6], zero pad
  input  logic [mme_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  logic [mme_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_row[2:0], out_col[5:3], out_value[40:6], zero pad
  output logic [mme_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_wdata_i
);
  import mme_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  state_e state_q, state_d;

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] ni, nk, nj;

  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  logic             in_xfer;
  cmd_e             in_cmd;
  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_value;
  logic             in_range;
  logic             start;

  logic             a_we, b_we;
  logic [AW-1:0]    waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;

  mac_ctl_t         mac_ctl;
  logic             mac_busy;
  logic [ACC_W-1:0] acc;

  logic             k_last, i_last, j_last;
  logic             out_free, load;

  logic             out_vld_q, out_vld_d;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic [ACC_W-1:0] out_value_q;
  logic             out_last_q;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
  assign in_xfer  = s_axis_tvalid & s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROWS_OF_A:  rows_q  <= cfg_wdata_i;
        REG_INNER_SIZE: inner_q <= cfg_wdata_i;
        REG_COLS_OF_B:  cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ni = (rows_q  > MAX_DIM_V) ? MAX_DIM_V : rows_q;
  assign nk = (inner_q > MAX_DIM_V) ? MAX_DIM_V : inner_q;
  assign nj = (cols_q  > MAX_DIM_V) ? MAX_DIM_V : cols_q;

  // element writes
  assign in_range = ({1'b0, in_row} < MAX_DIM_V) && ({1'b0, in_col} < MAX_DIM_V);
  assign a_we     = in_xfer && (in_cmd == CMD_WRITE_A) && in_range;
  assign b_we     = in_xfer && (in_cmd == CMD_WRITE_B) && in_range;
  assign waddr    = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));
  assign a_raddr  = AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(k_q));
  assign b_raddr  = AW'(AW'(k_q) * AW'(MAX_DIM) + AW'(j_q));

  assign start  = in_xfer && (in_cmd == CMD_COMPUTE) &&
                  (ni != '0) && (nj != '0);
  assign k_last = (nk == '0) || ({1'b0, k_q} == nk - 1'b1);
  assign i_last = ({1'b0, i_q} == ni - 1'b1);
  assign j_last = ({1'b0, j_q} == nj - 1'b1);

  assign out_free = !out_vld_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!mac_busy && out_free) begin
          state_d = (i_last && j_last) ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready  = 1'b0;
    mac_ctl.rd_vld = 1'b0;
    mac_ctl.clr    = 1'b0;
    load           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mac_ctl.clr   = 1'b1;
      end
      ST_RUN: begin
        mac_ctl.rd_vld = (nk != '0);
      end
      ST_WAIT: begin
        load        = !mac_busy && out_free;
        mac_ctl.clr = !mac_busy && out_free;
      end
      default: ;
    endcase
  end

  // loop counters: j outer, i middle, k inner
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (start) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (state_q == ST_RUN) begin
      k_d = k_last ? '0 : k_q + 1'b1;
    end else if (load) begin
      if (i_last) begin
        i_d = '0;
        j_d = j_q + 1'b1;
      end else begin
        i_d = i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  mme_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .a_we_i    (a_we),
    .b_we_i    (b_we),
    .waddr_i   (waddr),
    .wdata_i   (in_value),
    .rd_en_i   (mac_ctl.rd_vld),
    .a_raddr_i (a_raddr),
    .b_raddr_i (b_raddr),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  mme_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_row_q   <= i_q;
      out_col_q   <= j_q;
      out_value_q <= acc;
      out_last_q  <= i_last && j_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - ACC_W - 2*IDX_W){1'b0}},
                          out_value_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/mme_store.sv
module mme_store #(
  parameter int unsigned DEPTH = mme_pkg::MAX_DIM_DEF * mme_pkg::MAX_DIM_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk_i,
  input  logic                          a_we_i,
  input  logic                          b_we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [mme_pkg::VAL_W-1:0]     wdata_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 a_raddr_i,
  input  logic [AW-1:0]                 b_raddr_i,
  output logic [mme_pkg::VAL_W-1:0]     a_rdata_o,
  output logic [mme_pkg::VAL_W-1:0]     b_rdata_o
);
  import mme_pkg::*;

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];
  logic [VAL_W-1:0] a_rd_q;
  logic [VAL_W-1:0] b_rd_q;

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      mem_a[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      a_rd_q <= mem_a[a_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      mem_b[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      b_rd_q <= mem_b[b_raddr_i];
    end
  end

  assign a_rdata_o = a_rd_q;
  assign b_rdata_o = b_rd_q;

endmodule

FILE: rtl/mme_mac.sv
module mme_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mme_pkg::mac_ctl_t             ctl_i,
  input  logic [mme_pkg::VAL_W-1:0]     a_i,
  input  logic [mme_pkg::VAL_W-1:0]     b_i,
  output logic                          busy_o,
  output logic [mme_pkg::ACC_W-1:0]     acc_o
);
  import mme_pkg::*;

  logic                     s1_vld_q;
  logic                     s2_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         acc_d;

  assign prod_d = $signed(a_i) * $signed(b_i);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (s2_vld_q) begin
      acc_d = acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.rd_vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign busy_o = s1_vld_q | s2_vld_q;
  assign acc_o  = acc_q;

endmodule

FILE: verif/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int unsigned DIM          = MAX_DIM_DEF;
  localparam int          RANDOM_ITEMS = 20;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } mme_elem_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = CMD_NONE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_ROWS_OF_A;
  logic [DIM_W-1:0]      cfg_wdata_i   = '0;

  matrix_multiply_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the engine
  logic signed [VAL_W-1:0] a_store [DIM*DIM];
  logic signed [VAL_W-1:0] b_store [DIM*DIM];
  logic [DIM_W-1:0]        rows_dim  = DIM_RESET;
  logic [DIM_W-1:0]        inner_dim = DIM_RESET;
  logic [DIM_W-1:0]        cols_dim  = DIM_RESET;
  mme_elem_t               awaited_elements [$];

  int   items_sent      = 0;
  int   products_issued = 0;
  int   results_checked = 0;
  int   fail_count      = 0;
  logic bursts_on       = 1'b1;
  int   hold_seq        = 0;
  int   hold_seen       = 0;
  int   hold_left       = 0;
  int   stall_left      = 0;

  function automatic int clamp_dim(logic [DIM_W-1:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  function automatic void multiply_stores();
    int        ni;
    int        nk;
    int        nj;
    int        n;
    longint    acc;
    mme_elem_t e;
    ni = clamp_dim(rows_dim);
    nk = clamp_dim(inner_dim);
    nj = clamp_dim(cols_dim);
    n  = 0;
    for (int j = 0; j < nj; j++) begin
      for (int i = 0; i < ni; i++) begin
        acc = 0;
        for (int k = 0; k < nk; k++)
          acc += longint'(a_store[i*DIM+k]) * longint'(b_store[k*DIM+j]);
        n++;
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = acc[ACC_W-1:0];
        e.last  = (n == ni * nj);
        awaited_elements.push_back(e);
      end
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return DIM_W'($urandom_range(9, 15));
      2: return 4'd8;
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // receiver: random stalls plus an occasional long hold
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_element();
    mme_elem_t got;
    mme_elem_t want;
    got.row   = m_axis_tdata[2:0];
    got.col   = m_axis_tdata[5:3];
    got.value = m_axis_tdata[40:6];
    got.last  = m_axis_tlast;
    if (awaited_elements.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: row %0d col %0d value %0d last %0b",
                 got.row, got.col, $signed(got.value), got.last);
    end else begin
      want = awaited_elements.pop_front();
      results_checked++;
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result %0d: expected row %0d col %0d value %0d last %0b,",
                   results_checked, want.row, want.col, $signed(want.value), want.last);
          $display("  got row %0d col %0d value %0d last %0b",
                   got.row, got.col, $signed(got.value), got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_element();

  // enters and leaves at a falling edge; tvalid stays high for a following item
  task automatic send_item(input cmd_e cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, value, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    case (cmd)
      CMD_WRITE_A: a_store[{row, col}] = value;
      CMD_WRITE_B: b_store[{row, col}] = value;
      CMD_COMPUTE: begin
        multiply_stores();
        products_issued++;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (awaited_elements.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input reg_idx_e idx, input logic [DIM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROWS_OF_A:  rows_dim  = val;
      REG_INNER_SIZE: inner_dim = val;
      REG_COLS_OF_B:  cols_dim  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                          input logic [DIM_W-1:0] c);
    write_cfg(REG_ROWS_OF_A, r);
    write_cfg(REG_INNER_SIZE, k);
    write_cfg(REG_COLS_OF_B, c);
  endtask

  task automatic send_random_compute();
    send_item(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  // reset dimensions, every store entry loaded; row/col 0 give the widest sums
  task automatic test_default_dims();
    logic [VAL_W-1:0] v;
    for (int i = 0; i < DIM; i++)
      for (int k = 0; k < DIM; k++) begin
        v = (i == 0) ? 16'h8000 : (i == 1) ? 16'h7fff : rand_value();
        send_item(CMD_WRITE_A, IDX_W'(i), IDX_W'(k), v);
      end
    for (int k = 0; k < DIM; k++)
      for (int j = 0; j < DIM; j++) begin
        v = (j == 0) ? 16'h8000 : (j == 1) ? 16'h7fff : rand_value();
        send_item(CMD_WRITE_B, IDX_W'(k), IDX_W'(j), v);
      end
    send_random_compute();
    send_random_compute();
    end_stream();
    wait_idle();
  endtask

  task automatic test_extremes();
    set_dims(4'd1, 4'd2, 4'd1);
    send_item(CMD_WRITE_A, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_WRITE_A, 3'd0, 3'd1, 16'h8000);
    send_item(CMD_WRITE_B, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_WRITE_B, 3'd1, 3'd0, 16'h8000);
    send_random_compute();
    send_item(CMD_WRITE_A, 3'd0, 3'd1, 16'h7fff);
    send_item(CMD_WRITE_B, 3'd0, 3'd0, 16'hffff);
    send_random_compute();
    send_item(CMD_WRITE_B, 3'd1, 3'd0, 16'h7fff);
    send_item(CMD_WRITE_A, 3'd7, 3'd7, 16'h0000);
    send_random_compute();
    end_stream();
    wait_idle();
  endtask

  task automatic test_unused_command();
    send_item(CMD_NONE, 3'd7, 3'd7, 16'hffff);
    send_item(CMD_NONE, 3'd0, 3'd0, 16'h0000);
    send_random_compute();
    end_stream();
    wait_idle();
  endtask

  task automatic test_dimension_cases();
    set_dims(4'd0, 4'd3, 4'd4);
    send_random_compute();
    end_stream();
    wait_idle();
    set_dims(4'd3, 4'd0, 4'd2);
    send_random_compute();
    end_stream();
    wait_idle();
    set_dims(4'd2, 4'd3, 4'd0);
    send_random_compute();
    end_stream();
    wait_idle();
    set_dims(4'd15, 4'd9, 4'd12);
    send_random_compute();
    end_stream();
    wait_idle();
    set_dims(4'd1, 4'd1, 4'd1);
    write_cfg(REG_UNUSED, 4'hf);
    send_random_compute();
    end_stream();
    wait_idle();
  endtask

  // long receiver hold: output register fills and the input backs up
  task automatic test_output_hold();
    set_dims(4'd3, 4'd2, 4'd3);
    hold_seq++;
    send_random_compute();
    repeat (4)
      send_item(cmd_e'($urandom_range(0, 1)), IDX_W'($urandom), IDX_W'($urandom), rand_value());
    send_random_compute();
    send_random_compute();
    end_stream();
    wait_idle();
  endtask

  task automatic test_random_sequences();
    int target;
    int n;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 11))
          0: send_item(CMD_NONE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
          1, 2: send_random_compute();
          default: send_item(cmd_e'($urandom_range(0, 1)), IDX_W'($urandom),
                             IDX_W'($urandom), rand_value());
        endcase
      end
      send_random_compute();
      end_stream();
      wait_idle();
    end
  endtask

  task automatic test_full_rate();
    bursts_on = 1'b0;
    set_dims(4'd4, 4'd3, 4'd5);
    repeat (3) begin
      repeat (8)
        send_item(cmd_e'($urandom_range(0, 1)), IDX_W'($urandom), IDX_W'($urandom), rand_value());
      send_random_compute();
      send_random_compute();
    end
    end_stream();
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < DIM*DIM; i++) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_dims();
    test_extremes();
    test_unused_command();
    test_dimension_cases();
    test_output_hold();
    test_random_sequences();
    test_full_rate();
    if (awaited_elements.size() != 0) begin
      fail_count += awaited_elements.size();
      $display("%0d results never arrived", awaited_elements.size());
    end
    $display("%0d transfers in, %0d products, %0d results checked", items_sent,
             products_issued, results_checked);
    $display("dims from zero to saturated, long output hold, gap-free finish");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
